// ===== hw/rtl/sec_pkg.sv =====
// Shared types and constants for the scope edge trigger capture block.
// Holds field widths, command and register codes and the Q16 gain table.
// No dependencies.
`timescale 1ns / 1ps

package sec_pkg;

   localparam int RING_DEPTH_DEF   = 2048;
   localparam int SCREEN_WIDTH_DEF = 128;

   localparam int SCREEN_HEIGHT       = 128;
   localparam int PIXELS_PER_DIVISION = 20;
   localparam int SAMPLE_BITS         = 12;

   localparam int SAMPLE_W = 12;
   localparam int ROW_W    = 11;
   localparam int COL_W    = 7;
   localparam int CNT_W    = 16;
   localparam int CMD_W    = 2;
   localparam int VSCALE_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RISING_EDGE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTS_SCALE   = 2'd2;

   localparam logic [SAMPLE_W-1:0] LEVEL_RESET  = 12'd2048;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK  = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
   localparam logic [CNT_W-1:0]    CNT_MAX      = '1;
   localparam logic [ROW_W-1:0]    ROW_HALF     = ROW_W'(SCREEN_HEIGHT / 2);

   // gain = round(33 * ppd * 2^16 / (2^bits * tenths)), tenths = 1, 2, 5, 10, 20
   localparam longint unsigned GAIN_NUM  = 64'd33 * 64'(PIXELS_PER_DIVISION) * 64'd65536;
   localparam longint unsigned SAMPLE_FS = 64'd1 << SAMPLE_BITS;
   localparam longint unsigned GAIN_0 = (GAIN_NUM + (SAMPLE_FS * 1) / 2) / (SAMPLE_FS * 1);
   localparam longint unsigned GAIN_1 = (GAIN_NUM + (SAMPLE_FS * 2) / 2) / (SAMPLE_FS * 2);
   localparam longint unsigned GAIN_2 = (GAIN_NUM + (SAMPLE_FS * 5) / 2) / (SAMPLE_FS * 5);
   localparam longint unsigned GAIN_3 = (GAIN_NUM + (SAMPLE_FS * 10) / 2) / (SAMPLE_FS * 10);
   localparam longint unsigned GAIN_4 = (GAIN_NUM + (SAMPLE_FS * 20) / 2) / (SAMPLE_FS * 20);
   localparam int GAIN_BITS = $clog2(GAIN_0 + 1);
   localparam int PROD_W    = GAIN_BITS + SAMPLE_W + 2;

   function automatic logic [GAIN_BITS-1:0] gain_of(input logic [VSCALE_W-1:0] idx);
      logic [GAIN_BITS-1:0] g;
      case (idx)
         3'd0: begin
            g = GAIN_BITS'(GAIN_0);
         end
         3'd1: begin
            g = GAIN_BITS'(GAIN_1);
         end
         3'd2: begin
            g = GAIN_BITS'(GAIN_2);
         end
         3'd3: begin
            g = GAIN_BITS'(GAIN_3);
         end
         default: begin
            g = GAIN_BITS'(GAIN_4);
         end
      endcase
      return g;
   endfunction

endpackage

// ===== hw/rtl/scope_edge_trigger_capture.sv =====
// Top level of the scope edge trigger capture block: sequencer, registers, ports.
// Instantiates sec_ring, sec_scale and sec_frame. Depends on sec_pkg.
`timescale 1ns / 1ps

// A sample transfer leaves the block ready again straight away, so samples may
// stream at one per cycle while it is idle. A read transfer reads the frame store
// at the transfer edge and then loads the output register once the output is not
// stalled; the input stalls until the result is loaded. A capture transfer walks
// the sample ring through its single read port, one entry per cycle: a prime and
// load step, a search back over up to RING_DEPTH/2 entries, a copy of SCREEN_WIDTH
// entries through the shared scaling multiplier and a drain of the multiplier.
// The input is stalled until the drain ends. Ring entries never written since reset
// read as zero; no clearing pass is needed after reset. Configuration is accepted
// at any cycle.

module scope_edge_trigger_capture #(
   parameter int RING_DEPTH   = sec_pkg::RING_DEPTH_DEF,
   parameter int SCREEN_WIDTH = sec_pkg::SCREEN_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sec_pkg::CMD_W-1:0]           req_cmd,
   input  logic [sec_pkg::SAMPLE_W-1:0]        req_sample,
   input  logic                                req_overrun,
   input  logic [sec_pkg::COL_W-1:0]           req_column,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sec_pkg::ROW_W-1:0]    rsp_pixel_row,
   output logic [sec_pkg::COL_W-1:0]           rsp_column_echo,
   output logic                                rsp_trigger_found,
   output logic [sec_pkg::CNT_W-1:0]           rsp_overrun_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sec_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sec_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW     = $clog2(RING_DEPTH);
   localparam int FW     = $clog2(SCREEN_WIDTH);
   localparam int HALF_D = RING_DEPTH / 2;
   localparam int IW     = $clog2(HALF_D);
   localparam int HWM    = (SCREEN_WIDTH / 2) % RING_DEPTH;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_READ   = 7'b0000010,
      ST_PRIME  = 7'b0000100,
      ST_LOAD   = 7'b0001000,
      ST_SEARCH = 7'b0010000,
      ST_COPY   = 7'b0100000,
      ST_DRAIN  = 7'b1000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [sec_pkg::SAMPLE_W-1:0]     level_ff, level_in;
   logic                             rising_ff, rising_in;
   logic [sec_pkg::VSCALE_W-1:0]     vscale_ff, vscale_in;
   logic [AW-1:0]                    newest_ff, newest_in;
   logic [sec_pkg::CNT_W-1:0]        missed_ff, missed_in;
   logic                             found_ff, found_in;
   logic                             frame_ok_ff, frame_ok_in;
   logic [AW-1:0]                    x_ff, x_in;
   logic [AW-1:0]                    start_ff, start_in;
   logic [AW-1:0]                    pos_ff, pos_in;
   logic [sec_pkg::SAMPLE_W-1:0]     cur_ff, cur_in;
   logic [IW-1:0]                    iter_ff, iter_in;
   logic [FW-1:0]                    d_ff, d_in;
   logic                             copy_v_ff, copy_v_in;
   logic [FW-1:0]                    tag_ff, tag_in;
   logic [sec_pkg::COL_W-1:0]        col_ff, col_in;
   logic                             col_ok_ff, col_ok_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [sec_pkg::ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [sec_pkg::COL_W-1:0]        rsp_col_ff, rsp_col_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [sec_pkg::CNT_W-1:0]        rsp_cnt_ff, rsp_cnt_in;

   logic                             req_accept;
   logic                             rsp_load;
   logic [AW-1:0]                    newest_inc;
   logic [AW-1:0]                    xm1, xm2;
   logic [AW-1:0]                    ring_rd_addr;
   logic [sec_pkg::SAMPLE_W-1:0]     ring_q;
   logic                             ring_wr_en;
   logic                             hit;
   logic [AW-1:0]                    trig;
   logic                             search_done;
   logic                             scale_valid;
   logic signed [sec_pkg::ROW_W-1:0] scale_row;
   logic [FW-1:0]                    scale_tag;
   logic                             scale_busy;
   logic                             frame_rd_en;
   logic signed [sec_pkg::ROW_W-1:0] frame_q;

   function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
      return (a == '0) ? AW'(RING_DEPTH - 1) : a - 1'b1;
   endfunction

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
      return (a == AW'(RING_DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   // a minus half the screen width, modulo the ring depth
   function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] a);
      logic [AW:0] t;
      if ({1'b0, a} >= (AW + 1)'(HWM)) begin
         t = {1'b0, a} - (AW + 1)'(HWM);
      end else begin
         t = {1'b0, a} + (AW + 1)'(RING_DEPTH - HWM);
      end
      return t[AW-1:0];
   endfunction

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign newest_inc = ring_inc(newest_ff);
   assign ring_wr_en = req_accept && (req_cmd == sec_pkg::CMD_SAMPLE);
   assign frame_rd_en = req_accept && (req_cmd == sec_pkg::CMD_READ);
   assign xm1 = ring_dec(x_ff);
   assign xm2 = ring_dec(xm1);

   always_comb begin
      case (state_ff)
         ST_LOAD: begin
            ring_rd_addr = xm1;
         end
         ST_SEARCH: begin
            ring_rd_addr = xm2;
         end
         ST_COPY: begin
            ring_rd_addr = pos_ff;
         end
         default: begin
            ring_rd_addr = x_ff;
         end
      endcase
   end

   // ring_q is the previous sample of the pair while searching
   always_comb begin
      if (rising_ff) begin
         hit = (cur_ff >= level_ff) && (ring_q < level_ff);
      end else begin
         hit = (cur_ff <= level_ff) && (ring_q > level_ff);
      end
      search_done = hit || (iter_ff == IW'(HALF_D - 1));
      trig        = hit ? x_ff : start_ff;
   end

   always_comb begin
      level_in  = level_ff;
      rising_in = rising_ff;
      vscale_in = vscale_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            sec_pkg::CSR_TRIGGER_LEVEL: begin
               level_in = csr_wdata[sec_pkg::SAMPLE_W-1:0];
            end
            sec_pkg::CSR_RISING_EDGE: begin
               rising_in = csr_wdata[0];
            end
            sec_pkg::CSR_VOLTS_SCALE: begin
               vscale_in = csr_wdata[sec_pkg::VSCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      newest_in   = newest_ff;
      missed_in   = missed_ff;
      found_in    = found_ff;
      frame_ok_in = frame_ok_ff;
      x_in        = x_ff;
      start_in    = start_ff;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      iter_in     = iter_ff;
      d_in        = d_ff;
      copy_v_in   = 1'b0;
      tag_in      = tag_ff;
      col_in      = col_ff;
      col_ok_in   = col_ok_ff;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_cmd)
                  sec_pkg::CMD_SAMPLE: begin
                     newest_in = newest_inc;
                     if (req_overrun && (missed_ff != sec_pkg::CNT_MAX)) begin
                        missed_in = missed_ff + 1'b1;
                     end
                  end
                  sec_pkg::CMD_CAPTURE: begin
                     x_in     = ring_back(newest_ff);
                     start_in = ring_back(newest_ff);
                     state_in = ST_PRIME;
                  end
                  sec_pkg::CMD_READ: begin
                     col_in    = req_column;
                     col_ok_in = 32'(req_column) < SCREEN_WIDTH;
                     state_in  = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_PRIME: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cur_in   = ring_q;
            iter_in  = '0;
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (search_done) begin
               found_in    = hit;
               frame_ok_in = 1'b1;
               pos_in      = ring_back(trig);
               d_in        = '0;
               state_in    = ST_COPY;
            end else begin
               cur_in  = ring_q;
               x_in    = xm1;
               iter_in = iter_ff + 1'b1;
            end
         end
         ST_COPY: begin
            copy_v_in = 1'b1;
            tag_in    = d_ff;
            pos_in    = ring_inc(pos_ff);
            d_in      = d_ff + 1'b1;
            if (d_ff == FW'(SCREEN_WIDTH - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!copy_v_ff && !scale_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_found_in = rsp_found_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = (col_ok_ff && frame_ok_ff) ? frame_q : '0;
         rsp_col_in   = col_ff;
         rsp_found_in = found_ff;
         rsp_cnt_in   = missed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= sec_pkg::LEVEL_RESET;
         rising_ff    <= 1'b1;
         vscale_ff    <= '0;
         newest_ff    <= AW'(RING_DEPTH - 1);
         missed_ff    <= '0;
         found_ff     <= 1'b0;
         frame_ok_ff  <= 1'b0;
         copy_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rising_ff    <= rising_in;
         vscale_ff    <= vscale_in;
         newest_ff    <= newest_in;
         missed_ff    <= missed_in;
         found_ff     <= found_in;
         frame_ok_ff  <= frame_ok_in;
         copy_v_ff    <= copy_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      start_ff     <= start_in;
      pos_ff       <= pos_in;
      cur_ff       <= cur_in;
      iter_ff      <= iter_in;
      d_ff         <= d_in;
      tag_ff       <= tag_in;
      col_ff       <= col_in;
      col_ok_ff    <= col_ok_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_found_ff <= rsp_found_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   sec_ring #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_wr_en),
      .wr_addr (newest_inc),
      .wr_data (req_sample & sec_pkg::SAMPLE_MASK),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_q)
   );

   sec_scale #(
      .TAG_W (FW)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (copy_v_ff),
      .in_sample (ring_q),
      .in_level  (level_ff),
      .in_gain   (sec_pkg::gain_of(vscale_ff)),
      .in_tag    (tag_ff),
      .out_valid (scale_valid),
      .out_row   (scale_row),
      .out_tag   (scale_tag),
      .busy      (scale_busy)
   );

   sec_frame #(
      .DEPTH (SCREEN_WIDTH),
      .AW    (FW)
   ) u_frame (
      .clock   (clock),
      .wr_en   (scale_valid),
      .wr_addr (scale_tag),
      .wr_data (scale_row),
      .rd_en   (frame_rd_en),
      .rd_addr (FW'(req_column)),
      .rd_data (frame_q)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_row     = rsp_row_ff;
   assign rsp_column_echo   = rsp_col_ff;
   assign rsp_trigger_found = rsp_found_ff;
   assign rsp_overrun_count = rsp_cnt_ff;

endmodule

// ===== hw/rtl/sec_ring.sv =====
// Sample ring: one write and one registered read port per cycle.
// A fill count marks never-written entries, which read as zero.
// Depends on sec_pkg.
`timescale 1ns / 1ps

module sec_ring #(
   parameter int DEPTH = sec_pkg::RING_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [sec_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [sec_pkg::SAMPLE_W-1:0]  rd_data
);

   localparam int FCW = $clog2(DEPTH + 1);

   logic [sec_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [sec_pkg::SAMPLE_W-1:0] q_ff;
   logic                         rd_ok_ff;
   logic                         rd_ok_in;
   logic [FCW-1:0]               fill_ff;
   logic [FCW-1:0]               fill_in;

   // writes go to 0, 1, 2, ... after reset, so entry a is written once a < fill
   always_comb begin
      fill_in  = fill_ff;
      if (wr_en && (fill_ff != FCW'(DEPTH))) begin
         fill_in = fill_ff + 1'b1;
      end
      rd_ok_in = FCW'(rd_addr) < fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         rd_ok_ff <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ok_ff ? q_ff : '0;

endmodule

// ===== hw/rtl/sec_scale.sv =====
// Shared scaling unit: row = half height - round(gain * (sample - level)).
// Two stages: multiply, then round and offset. Depends on sec_pkg.
`timescale 1ns / 1ps

module sec_scale #(
   parameter int TAG_W = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [sec_pkg::SAMPLE_W-1:0]       in_sample,
   input  logic [sec_pkg::SAMPLE_W-1:0]       in_level,
   input  logic [sec_pkg::GAIN_BITS-1:0]      in_gain,
   input  logic [TAG_W-1:0]                   in_tag,
   output logic                               out_valid,
   output logic signed [sec_pkg::ROW_W-1:0]   out_row,
   output logic [TAG_W-1:0]                   out_tag,
   output logic                               busy
);

   localparam int PW = sec_pkg::PROD_W;

   logic signed [sec_pkg::SAMPLE_W:0] diff;
   logic signed [PW-1:0]              prod_in;
   logic signed [PW-1:0]              prod_ff;
   logic [TAG_W-1:0]                  tag1_ff;
   logic                              v1_ff;
   logic [PW-1:0]                     mag;
   logic [PW:0]                       rsum;
   logic [PW-16:0]                    rq;
   logic [sec_pkg::ROW_W-1:0]         r11;
   logic [sec_pkg::ROW_W-1:0]         row_in;
   logic [sec_pkg::ROW_W-1:0]         row_ff;
   logic [TAG_W-1:0]                  tag2_ff;
   logic                              v2_ff;

   always_comb begin
      diff    = $signed({1'b0, in_sample}) - $signed({1'b0, in_level});
      prod_in = $signed({1'b0, in_gain}) * diff;
   end

   // round half away from zero on the magnitude
   always_comb begin
      mag    = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
      rsum   = {1'b0, mag} + (PW + 1)'(32768);
      rq     = rsum[PW:16];
      r11    = sec_pkg::ROW_W'(rq);
      row_in = prod_ff[PW-1] ? (sec_pkg::ROW_HALF + r11) : (sec_pkg::ROW_HALF - r11);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      tag1_ff <= in_tag;
      row_ff  <= row_in;
      tag2_ff <= tag1_ff;
   end

   assign out_valid = v2_ff;
   assign out_row   = $signed(row_ff);
   assign out_tag   = tag2_ff;
   assign busy      = v1_ff | v2_ff;

endmodule

// ===== hw/rtl/sec_frame.sv =====
// Frame store of scaled rows, one per screen column.
// One write port and one registered read port. Depends on sec_pkg.
`timescale 1ns / 1ps

module sec_frame #(
   parameter int DEPTH = sec_pkg::SCREEN_WIDTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [AW-1:0]                      wr_addr,
   input  logic signed [sec_pkg::ROW_W-1:0]   wr_data,
   input  logic                               rd_en,
   input  logic [AW-1:0]                      rd_addr,
   output logic signed [sec_pkg::ROW_W-1:0]   rd_data
);

   logic signed [sec_pkg::ROW_W-1:0] mem [DEPTH];
   logic signed [sec_pkg::ROW_W-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   assign rd_data = q_ff;

endmodule

// ===== hw/rtl/sec_checker.sv =====
// Port-level checks for scope_edge_trigger_capture, bound to the top level.
// Depends on sec_pkg.
`timescale 1ns / 1ps

module sec_checker #(
   parameter int SCREEN_WIDTH = sec_pkg::SCREEN_WIDTH_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [sec_pkg::CMD_W-1:0]           req_cmd,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [sec_pkg::ROW_W-1:0]    rsp_pixel_row,
   input logic [sec_pkg::COL_W-1:0]           rsp_column_echo,
   input logic                                rsp_trigger_found,
   input logic [sec_pkg::CNT_W-1:0]           rsp_overrun_count
);

   logic req_xfer;
   assign req_xfer = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_row)
         && $stable(rsp_column_echo) && $stable(rsp_trigger_found)
         && $stable(rsp_overrun_count))
      else $error("result changed while stalled");

   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_cmd == sec_pkg::CMD_READ || req_cmd == sec_pkg::CMD_CAPTURE)
         |=> req_stall)
      else $error("input not stalled after read or capture transfer");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_xfer && req_cmd == sec_pkg::CMD_READ, 2))
      else $error("result without a read transfer");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (32'(rsp_column_echo) >= SCREEN_WIDTH) |-> rsp_pixel_row == '0)
      else $error("column beyond width gave a non-zero row");

endmodule

bind scope_edge_trigger_capture sec_checker #(
   .SCREEN_WIDTH (SCREEN_WIDTH)
) u_sec_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_cmd           (req_cmd),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_pixel_row     (rsp_pixel_row),
   .rsp_column_echo   (rsp_column_echo),
   .rsp_trigger_found (rsp_trigger_found),
   .rsp_overrun_count (rsp_overrun_count)
);
